// File: design/led_matrix_digit_grid_scanner_core_assert.svh
// assertion macros shared by the scanner modules
`ifndef LED_MATRIX_DIGIT_GRID_SCANNER_CORE_ASSERT_SVH
`define LED_MATRIX_DIGIT_GRID_SCANNER_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define LMDG_ASSERT_IMPL(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (con)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define LMDG_ASSERT_NEXT(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (con)) \
    else $error(msg);

`endif

// File: design/lmdg_pkg.sv
// types, constants and glyph/grid helpers for the digit grid scanner
package lmdg_pkg;

  localparam int PANEL_SIZE = 64;
  localparam int ROW_W      = $clog2(PANEL_SIZE);
  localparam int CELL_PITCH = 7;
  localparam int CELL_INNER = 6;
  localparam int GRID_CELLS = 9;
  localparam int HALF_ROWS  = 32;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_SCAN  = 1'b1;

  typedef struct packed {
    logic       func;
    logic [3:0] cell_row;
    logic [3:0] cell_col;
    logic [3:0] digit;
    logic [4:0] scan_row;
  } item_t;

  typedef struct packed {
    logic       upper_red;
    logic       lower_red;
    logic [5:0] column;
    logic [4:0] row_address;
    logic       last;
  } result_t;

  // classified command handed from the front to the back
  typedef struct packed {
    logic             is_scan;
    logic [ROW_W-1:0] top;
    logic [ROW_W-1:0] left;
    logic [3:0]       digit;
    logic [4:0]       scan_row;
  } cmd_t;

  // row k of a digit's 6x6 glyph, bit j lights interior column j
  function automatic logic [CELL_INNER-1:0] glyph_row(logic [3:0] dig, logic [2:0] k);
    logic [CELL_INNER*6-1:0] g;
    case (dig)
      4'd1:    g = {6'h3F, 6'h04, 6'h04, 6'h05, 6'h06, 6'h04};
      4'd2:    g = {6'h1E, 6'h02, 6'h02, 6'h1E, 6'h10, 6'h1E};
      4'd3:    g = {6'h1E, 6'h10, 6'h10, 6'h1E, 6'h10, 6'h1E};
      4'd4:    g = {6'h00, 6'h10, 6'h10, 6'h1E, 6'h12, 6'h12};
      4'd5:    g = {6'h1E, 6'h10, 6'h1E, 6'h02, 6'h02, 6'h1E};
      4'd6:    g = {6'h1E, 6'h12, 6'h1E, 6'h02, 6'h02, 6'h1E};
      4'd7:    g = {6'h10, 6'h10, 6'h10, 6'h10, 6'h10, 6'h1E};
      4'd8:    g = {6'h1E, 6'h12, 6'h1E, 6'h12, 6'h12, 6'h1E};
      4'd9:    g = {6'h10, 6'h10, 6'h1E, 6'h12, 6'h12, 6'h1E};
      default: g = '0;
    endcase
    case (k)
      3'd0:    glyph_row = g[5:0];
      3'd1:    glyph_row = g[11:6];
      3'd2:    glyph_row = g[17:12];
      3'd3:    glyph_row = g[23:18];
      3'd4:    glyph_row = g[29:24];
      3'd5:    glyph_row = g[35:30];
      default: glyph_row = '0;
    endcase
  endfunction

  // power-up contents of a frame row: grid lines at multiples of seven
  function automatic logic [PANEL_SIZE-1:0] reset_row(logic [ROW_W-1:0] idx);
    logic [PANEL_SIZE-1:0] cols;
    logic                  on_line;
    cols    = '0;
    on_line = 1'b0;
    for (int i = 0; i < PANEL_SIZE; i += CELL_PITCH) begin
      cols[i[ROW_W-1:0]] = 1'b1;
      if (idx == i[ROW_W-1:0]) on_line = 1'b1;
    end
    reset_row = on_line ? '1 : cols;
  endfunction

endpackage

// File: design/led_matrix_digit_grid_scanner_core.sv
// top level of the led matrix digit grid scanner
//
//   channel   direction   handshake            payload
//   item      in          push / full          lmdg_pkg::item_t
//   result    out         pop / empty          lmdg_pkg::result_t
//
// scan: a dispatch, two frame memory reads and a capture, then one result per cycle
//   for 64 columns when pop keeps up
// digit write: a dispatch, then a read and a write back for each of the six interior rows
// the front queue holds two commands; writes with digit zero or outside the grid take no back-end time
// reset marks all frame rows unwritten so they read as the grid at once, no clearing pass
// a stalled result holds the shift-out; pushes continue until the queue fills
module led_matrix_digit_grid_scanner_core (
  input  logic             clk,
  input  logic             rst,
  input  lmdg_pkg::item_t   item,
  input  logic             push,
  output logic             full,
  output lmdg_pkg::result_t result,
  output logic             empty,
  input  logic             pop
);
  import lmdg_pkg::*;

  cmd_t cmd_head;
  logic cmd_avail;
  logic cmd_take;

  lmdg_front u_front (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .push      (push),
    .full      (full),
    .cmd_head  (cmd_head),
    .cmd_avail (cmd_avail),
    .cmd_take  (cmd_take)
  );

  lmdg_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_head  (cmd_head),
    .cmd_avail (cmd_avail),
    .cmd_take  (cmd_take),
    .result    (result),
    .empty     (empty),
    .pop       (pop)
  );

endmodule

// File: design/lmdg_ram.sv
// generic single-write, single-read ram with registered read data
module lmdg_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

endmodule

// File: design/lmdg_front.sv
// front end: accepts items, drops no-op writes, queues commands for the back end
`include "led_matrix_digit_grid_scanner_core_assert.svh"

module lmdg_front (
  input  logic           clk,
  input  logic           rst,
  input  lmdg_pkg::item_t item,
  input  logic           push,
  output logic           full,
  output lmdg_pkg::cmd_t  cmd_head,
  output logic           cmd_avail,
  input  logic           cmd_take
);
  import lmdg_pkg::*;

  localparam int QDEPTH = 2;

  cmd_t       queue [QDEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] cnt;
  logic [1:0] cnt_next;

  cmd_t cmd_new;
  logic keep;
  logic accept;
  logic take;

  // writes with digit zero or outside the grid change nothing
  assign keep = (item.func == FUNC_SCAN) ||
                ((item.digit != 4'd0) &&
                 (item.cell_row < 4'(GRID_CELLS)) &&
                 (item.cell_col < 4'(GRID_CELLS)));

  always_comb begin
    cmd_new.is_scan  = (item.func == FUNC_SCAN);
    cmd_new.top      = ROW_W'({2'b00, item.cell_row} * ROW_W'(CELL_PITCH) + ROW_W'(1));
    cmd_new.left     = ROW_W'({2'b00, item.cell_col} * ROW_W'(CELL_PITCH) + ROW_W'(1));
    cmd_new.digit    = item.digit;
    cmd_new.scan_row = item.scan_row;
  end

  assign full      = (cnt == 2'(QDEPTH));
  assign accept    = push && !full;
  assign cmd_avail = (cnt != 2'd0);
  assign take      = cmd_take && cmd_avail;
  assign cmd_head  = queue[rd_ptr];

  always_comb begin
    cnt_next = cnt;
    if ((accept && keep) && !take) cnt_next = cnt + 2'd1;
    else if (!(accept && keep) && take) cnt_next = cnt - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (accept && keep) begin
        queue[wr_ptr] <= cmd_new;
        wr_ptr        <= ~wr_ptr;
      end
      if (take) rd_ptr <= ~rd_ptr;
      cnt <= cnt_next;
    end
  end

  `LMDG_ASSERT_IMPL(a_cnt_bound, 1'b1, cnt <= 2'(QDEPTH), "command queue overfilled")
  `LMDG_ASSERT_IMPL(a_take_nonempty, cmd_take, cnt != 2'd0, "command taken from empty queue")
  `LMDG_ASSERT_NEXT(a_enqueue_grows, accept && keep && !take, cnt == $past(cnt) + 2'd1,
                    "queued transaction not counted")

endmodule

// File: design/lmdg_back.sv
// back end: frame memory, digit read-modify-write and row pair shift-out
`include "led_matrix_digit_grid_scanner_core_assert.svh"

module lmdg_back (
  input  logic             clk,
  input  logic             rst,
  input  lmdg_pkg::cmd_t    cmd_head,
  input  logic             cmd_avail,
  output logic             cmd_take,
  output lmdg_pkg::result_t result,
  output logic             empty,
  input  logic             pop
);
  import lmdg_pkg::*;

  localparam logic [2:0]       INNER_LAST = 3'(CELL_INNER - 1);
  localparam logic [ROW_W-1:0] COL_LAST   = ROW_W'(PANEL_SIZE - 1);

  typedef enum logic [2:0] {
    IDLE, W_RD, W_WR, S_RDU, S_RDL, S_CAP, S_SHIFT
  } state_t;

  state_t                state;
  cmd_t                  cmd;
  logic [2:0]            k;
  logic [ROW_W-1:0]      col;
  logic [PANEL_SIZE-1:0] upper_sh;
  logic [PANEL_SIZE-1:0] lower_sh;
  logic [PANEL_SIZE-1:0] row_ok;
  logic [ROW_W-1:0]      rd_addr_q;
  logic                  rd_ok_q;
  result_t               res_q;
  logic                  res_valid;

  logic                  rd_en;
  logic [ROW_W-1:0]      rd_addr;
  logic [PANEL_SIZE-1:0] rd_data;
  logic [PANEL_SIZE-1:0] row_word;
  logic                  wr_en;
  logic [PANEL_SIZE-1:0] wr_data;
  logic [PANEL_SIZE-1:0] inner_mask;
  logic [PANEL_SIZE-1:0] glyph_bits;
  logic                  emit;
  result_t               res_new;

  assign rd_en = (state == W_RD) || (state == S_RDU) || (state == S_RDL);

  always_comb begin
    case (state)
      W_RD:    rd_addr = cmd.top + ROW_W'(k);
      S_RDU:   rd_addr = {1'b0, cmd.scan_row};
      default: rd_addr = {1'b1, cmd.scan_row};
    endcase
  end

  // rows never written still hold the power-up grid
  assign row_word = rd_ok_q ? rd_data : reset_row(rd_addr_q);

  assign inner_mask = {{(PANEL_SIZE-CELL_INNER){1'b0}}, {CELL_INNER{1'b1}}} << cmd.left;
  assign glyph_bits = {{(PANEL_SIZE-CELL_INNER){1'b0}}, glyph_row(cmd.digit, k)} << cmd.left;
  assign wr_en      = (state == W_WR);
  assign wr_data    = (row_word & ~inner_mask) | glyph_bits;

  lmdg_ram #(
    .WIDTH (PANEL_SIZE),
    .DEPTH (PANEL_SIZE)
  ) u_frame (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (rd_addr_q),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign cmd_take = (state == IDLE) && cmd_avail;
  assign emit     = (state == S_SHIFT) && (!res_valid || pop);

  always_comb begin
    res_new.upper_red   = upper_sh[0];
    res_new.lower_red   = lower_sh[0];
    res_new.column      = col;
    res_new.last        = (col == COL_LAST);
    res_new.row_address = (col == COL_LAST) ? cmd.scan_row : 5'd0;
  end

  assign result = res_q;
  assign empty  = !res_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      res_valid <= 1'b0;
      row_ok    <= '0;
    end else begin
      rd_addr_q <= rd_addr;
      rd_ok_q   <= row_ok[rd_addr];
      if (wr_en) row_ok[rd_addr_q] <= 1'b1;

      if (emit) begin
        res_q     <= res_new;
        res_valid <= 1'b1;
      end else if (pop) begin
        res_valid <= 1'b0;
      end

      case (state)
        IDLE: begin
          if (cmd_avail) begin
            cmd   <= cmd_head;
            k     <= 3'd0;
            state <= cmd_head.is_scan ? S_RDU : W_RD;
          end
        end
        W_RD: state <= W_WR;
        W_WR: begin
          if (k == INNER_LAST) begin
            state <= IDLE;
          end else begin
            k     <= k + 3'd1;
            state <= W_RD;
          end
        end
        S_RDU: state <= S_RDL;
        S_RDL: begin
          upper_sh <= row_word;
          state    <= S_CAP;
        end
        S_CAP: begin
          lower_sh <= row_word;
          col      <= '0;
          state    <= S_SHIFT;
        end
        S_SHIFT: begin
          if (emit) begin
            upper_sh <= upper_sh >> 1;
            lower_sh <= lower_sh >> 1;
            col      <= col + ROW_W'(1);
            if (col == COL_LAST) state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  `LMDG_ASSERT_IMPL(a_last_col, res_valid && res_q.last, res_q.column == COL_LAST,
                    "latch flagged off the final column")
  `LMDG_ASSERT_IMPL(a_addr_only_last, res_valid && !res_q.last, res_q.row_address == 5'd0,
                    "row address driven before latch")
  `LMDG_ASSERT_NEXT(a_scan_done, emit && (col == COL_LAST), state == IDLE,
                    "scan did not finish after final column")

endmodule

// File: verif/tb_led_matrix_digit_grid_scanner_core.sv
`timescale 1ns / 1ps
// testbench for the digit grid scanner core: digit writes and row scans checked pixel by pixel
module tb_led_matrix_digit_grid_scanner_core;
  import lmdg_pkg::*;

  typedef struct packed {
    logic  wait_idle;
    item_t payload;
  } pending_t;

  typedef enum logic [1:0] {POP_FREE, POP_CHOPPY, POP_SLOW} pop_mode_t;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  item_t   item = '0;
  logic    push = 1'b0;
  logic    full;
  result_t result;
  logic    empty;
  logic    pop = 1'b0;

  logic [PANEL_SIZE-1:0] panel_rows [0:PANEL_SIZE-1];
  pending_t    pending_items [$];
  result_t     expected_pixels [$];
  int unsigned accepted_cnt = 0;
  int unsigned taken_cnt = 0;
  int unsigned error_cnt = 0;
  int unsigned item_total = 0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned pop_run = 0;
  pop_mode_t   pop_mode = POP_FREE;

  led_matrix_digit_grid_scanner_core u_top (
    .clk   (clk),
    .rst   (rst),
    .item  (item),
    .push  (push),
    .full  (full),
    .result(result),
    .empty (empty),
    .pop   (pop)
  );

  always #5 clk = ~clk;

  // interior row k of a digit glyph; rows listed top first, bit j is interior column j
  function automatic logic [5:0] glyph_row(logic [3:0] dig, int k);
    logic [35:0] g;
    case (dig)
      4'd1:    g = {6'h04, 6'h06, 6'h05, 6'h04, 6'h04, 6'h3F};
      4'd2:    g = {6'h1E, 6'h10, 6'h1E, 6'h02, 6'h02, 6'h1E};
      4'd3:    g = {6'h1E, 6'h10, 6'h1E, 6'h10, 6'h10, 6'h1E};
      4'd4:    g = {6'h12, 6'h12, 6'h1E, 6'h10, 6'h10, 6'h00};
      4'd5:    g = {6'h1E, 6'h02, 6'h02, 6'h1E, 6'h10, 6'h1E};
      4'd6:    g = {6'h1E, 6'h02, 6'h02, 6'h1E, 6'h12, 6'h1E};
      4'd7:    g = {6'h1E, 6'h10, 6'h10, 6'h10, 6'h10, 6'h10};
      4'd8:    g = {6'h1E, 6'h12, 6'h12, 6'h1E, 6'h12, 6'h1E};
      4'd9:    g = {6'h1E, 6'h12, 6'h12, 6'h1E, 6'h10, 6'h10};
      default: g = '0;
    endcase
    glyph_row = g[35-6*k -: 6];
  endfunction

  function automatic item_t make_item(logic f, logic [3:0] cr, logic [3:0] cc,
                                      logic [3:0] dg, logic [4:0] sr);
    item_t it;
    it.func     = f;
    it.cell_row = cr;
    it.cell_col = cc;
    it.digit    = dg;
    it.scan_row = sr;
    make_item = it;
  endfunction

  task automatic queue_item(input item_t it, input logic wait_idle);
    pending_t p;
    p.wait_idle = wait_idle;
    p.payload   = it;
    pending_items.push_back(p);
  endtask

  // update the frame on a write, or queue the 64 pixels a scan shifts out
  task automatic predict_panel(input item_t it);
    logic [PANEL_SIZE-1:0] mask;
    logic [PANEL_SIZE-1:0] g;
    int top;
    int left;
    int k;
    int c;
    int lo_row;
    result_t px;
    if (it.func == FUNC_WRITE) begin
      if (it.digit == 4'd0 || int'(it.cell_row) >= GRID_CELLS ||
          int'(it.cell_col) >= GRID_CELLS)
        return;
      top  = int'(it.cell_row) * CELL_PITCH + 1;
      left = int'(it.cell_col) * CELL_PITCH + 1;
      mask = {{(PANEL_SIZE-6){1'b0}}, 6'h3F} << left;
      for (k = 0; k < CELL_INNER; k++) begin
        g = '0;
        g[5:0] = glyph_row(it.digit, k);
        panel_rows[top+k] = (panel_rows[top+k] & ~mask) | (g << left);
      end
    end else begin
      lo_row = int'(it.scan_row) + HALF_ROWS;
      for (c = 0; c < PANEL_SIZE; c++) begin
        px.upper_red   = panel_rows[int'(it.scan_row)][c];
        px.lower_red   = panel_rows[lo_row][c];
        px.column      = c[5:0];
        px.last        = (c == PANEL_SIZE - 1);
        px.row_address = px.last ? it.scan_row : 5'd0;
        expected_pixels.push_back(px);
      end
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_cnt++;
    end
  endtask

  always @(posedge clk) begin : monitor
    result_t want;
    if (!rst) begin
      if (push && !full) begin
        predict_panel(item);
        accepted_cnt <= accepted_cnt + 1;
      end
      if (pop && !empty) begin
        if (expected_pixels.size() == 0) begin
          $error("result transaction with no scan outstanding, column %0d", result.column);
          error_cnt++;
        end else begin
          want = expected_pixels.pop_front();
          check_field("upper_red", 8'(want.upper_red), 8'(result.upper_red));
          check_field("lower_red", 8'(want.lower_red), 8'(result.lower_red));
          check_field("column", 8'(want.column), 8'(result.column));
          check_field("row_address", 8'(want.row_address), 8'(result.row_address));
          check_field("last", 8'(want.last), 8'(result.last));
        end
      end
    end
  end

  always @(negedge clk) begin : driver
    logic took;
    logic next_push;
    took      = 1'b0;
    next_push = 1'b0;
    if (!rst) begin
      if (taken_cnt != accepted_cnt) begin
        void'(pending_items.pop_front());
        taken_cnt++;
        took = 1'b1;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 16);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
      if (push && !took) begin
        next_push = 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
      end else if (pending_items.size() > 0) begin
        // some items hold off until every queued pixel has been read out
        if (!pending_items[0].wait_idle || expected_pixels.size() == 0) begin
          next_push = 1'b1;
          item <= pending_items[0].payload;
        end
      end
    end
    push <= next_push;
  end

  always @(negedge clk) begin : receiver
    if (pop_run == 0) begin
      pop_mode = pop_mode_t'($urandom_range(0, 2));
      pop_run  = $urandom_range(16, 160);
    end else begin
      pop_run--;
    end
    case (pop_mode)
      POP_FREE:   pop <= !rst;
      POP_CHOPPY: pop <= !rst && ($urandom_range(0, 2) != 0);
      default:    pop <= !rst && ($urandom_range(0, 4) == 0);
    endcase
  end

  initial begin : stimulus
    logic [PANEL_SIZE-1:0] grid_cols;
    item_t it;
    int    sel;
    int    i;

    grid_cols = '0;
    for (i = 0; i < PANEL_SIZE; i += CELL_PITCH) grid_cols[i] = 1'b1;
    for (i = 0; i < PANEL_SIZE; i++) panel_rows[i] = (i % CELL_PITCH == 0) ? '1 : grid_cols;

    // untouched grid, both ends of the row range
    queue_item(make_item(FUNC_SCAN, 4'hF, 4'hF, 4'hF, 5'd0), 1'b0);
    queue_item(make_item(FUNC_SCAN, 4'h0, 4'h0, 4'h0, 5'd31), 1'b0);
    // every glyph, corner cells included
    queue_item(make_item(FUNC_WRITE, 4'd0, 4'd0, 4'd1, 5'($urandom)), 1'b0);
    queue_item(make_item(FUNC_WRITE, 4'd8, 4'd8, 4'd2, 5'($urandom)), 1'b0);
    queue_item(make_item(FUNC_WRITE, 4'd0, 4'd8, 4'd3, 5'($urandom)), 1'b0);
    queue_item(make_item(FUNC_WRITE, 4'd8, 4'd0, 4'd4, 5'($urandom)), 1'b0);
    queue_item(make_item(FUNC_WRITE, 4'd4, 4'd4, 4'd5, 5'($urandom)), 1'b0);
    queue_item(make_item(FUNC_WRITE, 4'd2, 4'd6, 4'd6, 5'($urandom)), 1'b0);
    queue_item(make_item(FUNC_WRITE, 4'd6, 4'd2, 4'd7, 5'($urandom)), 1'b0);
    queue_item(make_item(FUNC_WRITE, 4'd1, 4'd1, 4'd8, 5'($urandom)), 1'b0);
    queue_item(make_item(FUNC_WRITE, 4'd7, 4'd7, 4'd9, 5'($urandom)), 1'b0);
    // digit zero keeps the glyph, blank digits wipe the interior
    queue_item(make_item(FUNC_WRITE, 4'd0, 4'd0, 4'd0, 5'($urandom)), 1'b0);
    queue_item(make_item(FUNC_WRITE, 4'd4, 4'd4, 4'd10, 5'($urandom)), 1'b0);
    queue_item(make_item(FUNC_WRITE, 4'd8, 4'd8, 4'd15, 5'($urandom)), 1'b0);
    // cells outside the grid are ignored
    queue_item(make_item(FUNC_WRITE, 4'd9, 4'd3, 4'd5, 5'($urandom)), 1'b0);
    queue_item(make_item(FUNC_WRITE, 4'd3, 4'd15, 4'd6, 5'($urandom)), 1'b0);
    queue_item(make_item(FUNC_WRITE, 4'd15, 4'd0, 4'd1, 5'($urandom)), 1'b0);
    // rows crossing the drawn cells
    queue_item(make_item(FUNC_SCAN, 4'($urandom), 4'($urandom), 4'($urandom), 5'd1), 1'b0);
    queue_item(make_item(FUNC_SCAN, 4'($urandom), 4'($urandom), 4'($urandom), 5'd4), 1'b0);
    queue_item(make_item(FUNC_SCAN, 4'($urandom), 4'($urandom), 4'($urandom), 5'd25), 1'b0);
    queue_item(make_item(FUNC_SCAN, 4'($urandom), 4'($urandom), 4'($urandom), 5'd30), 1'b0);
    queue_item(make_item(FUNC_SCAN, 4'($urandom), 4'($urandom), 4'($urandom), 5'd29), 1'b1);

    while (pending_items.size() < 380) begin
      sel = $urandom_range(0, 99);
      it  = make_item(1'($urandom), 4'($urandom), 4'($urandom), 4'($urandom), 5'($urandom));
      if (sel < 45) begin
        it.func = FUNC_SCAN;
      end else if (sel < 85) begin
        it.func     = FUNC_WRITE;
        it.cell_row = 4'($urandom_range(0, GRID_CELLS - 1));
        it.cell_col = 4'($urandom_range(0, GRID_CELLS - 1));
        it.digit    = 4'($urandom_range(1, 15));
      end else begin
        // raw write: mostly off-grid or digit zero
        it.func = FUNC_WRITE;
      end
      queue_item(it, $urandom_range(0, 59) == 0);
    end
    item_total = pending_items.size();

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (accepted_cnt != item_total || expected_pixels.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (error_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+design
design/lmdg_pkg.sv
design/lmdg_ram.sv
design/lmdg_front.sv
design/lmdg_back.sv
design/led_matrix_digit_grid_scanner_core.sv
verif/tb_led_matrix_digit_grid_scanner_core.sv
